// ===== design/fhp_pkg.sv =====
// shared types and constants of the first-fit heap packer
package fhp_pkg;

  localparam int TYPE_W  = 16;
  localparam int SIZE_W  = 40;
  localparam int LG_W    = 5;
  localparam int LIMIT_W = 41;
  localparam int END_W   = 42;
  localparam int IDX_W   = 3;
  localparam int WK_W    = 44;

  localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(64'd268435456);

  // configuration register indexes
  localparam logic REG_HEAP_LIMIT = 1'b0;
  localparam logic REG_GRAN_LOG2  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BASE,
    S_OFFS,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 must_be_dedicated;
    logic                 is_texture;
    logic [LG_W-1:0]      alignment_log2;
    logic [SIZE_W-1:0]    request_size;
    logic [TYPE_W-1:0]    memory_type;
  } req_t;

  typedef struct packed {
    logic                 has_texture;
    logic [TYPE_W-1:0]    mem_type;
    logic [END_W-1:0]     heap_end;
  } ent_t;

  typedef struct packed {
    logic                 no_heap_left;
    logic                 opened_heap;
    logic [END_W-1:0]     placed_offset;
    logic [IDX_W-1:0]     heap_index;
    logic                 dedicated;
  } res_t;

endpackage

// ===== design/fhp_heap_mem.sv =====
// heap table memory, one write and one registered read per cycle
module fhp_heap_mem import fhp_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  ent_t          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output ent_t          rdata_o
);

  ent_t mem [DEPTH];
  ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fhp_engine.sv =====
// first-fit scan sequencer and placement datapath
module fhp_engine import fhp_pkg::*; #(
  parameter int MAX_HEAPS = 8,
  parameter int AW        = 3,
  parameter int IW        = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_vld_i,
  output logic               req_rdy_o,
  input  req_t               req_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic [LG_W-1:0]    gran_i,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  ent_t               mem_rdata_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output ent_t               mem_wdata_o,
  output logic               res_vld_o,
  input  logic               res_rdy_i,
  output res_t               res_o
);

  function automatic logic [WK_W-1:0] align_up(input logic [WK_W-1:0] x,
                                                input logic [LG_W-1:0] lg);
    logic [WK_W-1:0] m;
    m = (WK_W'(1) << lg) - WK_W'(1);
    return (x + m) & ~m;
  endfunction

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   open_q, open_d;
  logic            chk_vld_q, chk_vld_d;
  logic [AW-1:0]   chk_idx_q, chk_idx_d;
  logic [AW-1:0]   sel_q, sel_d;
  logic [WK_W-1:0] wk_q, wk_d;
  logic            has_tex_q, has_tex_d;
  logic            opened_q, opened_d;
  logic            noleft_q, noleft_d;

  logic            issue, hit, miss_done, full, place;
  logic [WK_W-1:0] fit_sum;
  logic [WK_W-1:0] off_al;
  logic [END_W-1:0] new_end;

  assign issue     = (idx_q < open_q);
  assign fit_sum   = align_up({2'b00, mem_rdata_i.heap_end}, req_q.alignment_log2)
                   + {4'b0000, req_q.request_size};
  assign hit       = chk_vld_q && (mem_rdata_i.mem_type == req_q.memory_type)
                   && (fit_sum <= {3'b000, limit_i});
  assign miss_done = !hit && !issue;
  assign full      = (open_q == IW'(MAX_HEAPS));
  assign place     = !req_q.must_be_dedicated && !noleft_q;
  assign off_al    = align_up(wk_q, req_q.alignment_log2);
  assign new_end   = wk_q[END_W-1:0] + {2'b00, req_q.request_size};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_vld_i) begin
          state_d = req_i.must_be_dedicated ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_BASE;
        end else if (miss_done) begin
          state_d = full ? S_DONE : S_BASE;
        end
      end
      S_BASE:  state_d = S_OFFS;
      S_OFFS:  state_d = S_DONE;
      S_DONE: begin
        if (res_rdy_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    open_d      = open_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    sel_d       = sel_q;
    wk_d        = wk_q;
    has_tex_d   = has_tex_q;
    opened_d    = opened_q;
    noleft_d    = noleft_q;
    req_rdy_o   = 1'b0;
    mem_re_o    = 1'b0;
    mem_we_o    = 1'b0;
    res_vld_o   = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    mem_waddr_o = sel_q;
    mem_wdata_o.has_texture = has_tex_q | req_q.is_texture;
    mem_wdata_o.mem_type    = req_q.memory_type;
    mem_wdata_o.heap_end    = new_end;
    res_o.dedicated     = req_q.must_be_dedicated;
    res_o.no_heap_left  = noleft_q;
    res_o.opened_heap   = place & opened_q;
    res_o.heap_index    = place ? IDX_W'(sel_q) : '0;
    res_o.placed_offset = place ? wk_q[END_W-1:0] : '0;
    case (state_q)
      S_IDLE: begin
        req_rdy_o = 1'b1;
        if (req_vld_i) begin
          req_d    = req_i;
          idx_d    = '0;
          opened_d = 1'b0;
          noleft_d = 1'b0;
        end
      end
      S_SCAN: begin
        // one entry read per cycle, checked the cycle after
        if (issue) begin
          mem_re_o  = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + IW'(1);
        end
        if (hit) begin
          sel_d     = chk_idx_q;
          wk_d      = {2'b00, mem_rdata_i.heap_end};
          has_tex_d = mem_rdata_i.has_texture;
        end else if (miss_done) begin
          if (full) begin
            noleft_d = 1'b1;
          end else begin
            sel_d     = open_q[AW-1:0];
            wk_d      = '0;
            has_tex_d = 1'b0;
            opened_d  = 1'b1;
          end
        end
      end
      S_BASE: begin
        // first texture in a heap starts on a granularity boundary
        if (req_q.is_texture && !has_tex_q) begin
          wk_d = align_up(wk_q, gran_i);
        end
      end
      S_OFFS: begin
        wk_d = {2'b00, off_al[END_W-1:0]};
      end
      S_DONE: begin
        if (res_rdy_i) begin
          res_vld_o = 1'b1;
          mem_we_o  = place;
          if (place && opened_q) begin
            open_d = open_q + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      open_q    <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    sel_q     <= sel_d;
    wk_q      <= wk_d;
    has_tex_q <= has_tex_d;
    opened_q  <= opened_d;
    noleft_q  <= noleft_d;
  end

endmodule

// ===== design/first_fit_heap_packer.sv =====
// sequence: a dedicated request goes from idle straight to the done state;
// a placed request runs the first-fit scan, reading one heap entry a cycle from
// the heap memory, then the base and offset alignment steps and the done state
// throughput: one request at a time, the next is taken once the engine is idle
// reset: asynchronous active low, clears control state, open heap count and
// both configuration registers; the heap memory needs no clearing pass
module first_fit_heap_packer import fhp_pkg::*; #(
  parameter int MAX_HEAPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // memory_type, request_size, alignment_log2, must_be_dedicated, zero pad
  input  logic [63:0]        s_axis_tdata_i,
  // is_texture
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // dedicated, heap_index, placed_offset, opened_heap, no_heap_left
  output logic [47:0]        m_axis_tdata_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  localparam int AW = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
  localparam int IW = $clog2(MAX_HEAPS + 1);

  logic [LIMIT_W-1:0] limit_q;
  logic [LG_W-1:0]    gran_q;
  logic [LIMIT_W-1:0] limit_eff;

  req_t          req;
  res_t          res;
  logic          res_vld, res_rdy;
  logic          out_vld_q;
  res_t          out_q;

  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  ent_t          mem_rdata, mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      gran_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAP_LIMIT: limit_q <= cfg_data_i;
        REG_GRAN_LOG2:  gran_q  <= cfg_data_i[LG_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit_eff = (limit_q == '0) ? DEFAULT_LIMIT : limit_q;

  assign req.memory_type       = s_axis_tdata_i[15:0];
  assign req.request_size      = s_axis_tdata_i[55:16];
  assign req.alignment_log2    = s_axis_tdata_i[60:56];
  assign req.must_be_dedicated = s_axis_tdata_i[61];
  assign req.is_texture        = s_axis_tuser_i;

  fhp_engine #(
    .MAX_HEAPS (MAX_HEAPS),
    .AW        (AW),
    .IW        (IW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_vld_i   (s_axis_tvalid_i),
    .req_rdy_o   (s_axis_tready_o),
    .req_i       (req),
    .limit_i     (limit_eff),
    .gran_i      (gran_q),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .res_vld_o   (res_vld),
    .res_rdy_i   (res_rdy),
    .res_o       (res)
  );

  fhp_heap_mem #(
    .DEPTH (MAX_HEAPS),
    .AW    (AW)
  ) u_heap_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register, takes a new result when empty or being drained
  assign res_rdy = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_rdy) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_rdy && res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ===== design/fhp_checker.sv =====
// port-level checks of the heap packer and their binding
module fhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

  a_ded_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[47:1] == 47'd0)
    else $error("dedicated result carries placement");

  a_noleft_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[47] |-> m_axis_tdata_o[46:0] == 47'd0)
    else $error("failed placement carries placement");

  // an opened heap is never reported on a dedicated or failed request
  a_open_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[46] |-> !m_axis_tdata_o[0] && !m_axis_tdata_o[47])
    else $error("opened heap with conflicting flags");

endmodule

bind first_fit_heap_packer fhp_checker u_fhp_checker (.*);
